// ----- rtl/sbpf_pkg.sv -----
// Shared types and constants for the servo-bus packet framer/checker.
// No dependencies; imported by every module of the block.
`default_nettype none

package sbpf_pkg;

  // Parameter count saturates at this value
  localparam int MAX_PARAMS = 127;
  // Default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] BROADCAST_RESET = 8'hFE;
  localparam logic [7:0] SYNC_BYTE       = 8'hFF;
  localparam logic [7:0] SUM_GOOD        = 8'hFF;
  localparam logic [7:0] COLLECT_ALL     = 8'hFF;
  localparam logic [7:0] MIN_CHECKED     = 8'd4;
  localparam logic [7:0] LEN_OVERHEAD    = 8'd2;
  localparam logic [7:0] REPLY_HDR_BYTES = 8'd4;

  // Reply byte positions
  localparam logic [7:0] POS_ID     = 8'd2;
  localparam logic [7:0] POS_LENGTH = 8'd3;

  // Output steps of a start command
  localparam logic [2:0] STEP_SYNC0 = 3'd0;
  localparam logic [2:0] STEP_SYNC1 = 3'd1;
  localparam logic [2:0] STEP_ID    = 3'd2;
  localparam logic [2:0] STEP_LEN   = 3'd3;
  localparam logic [2:0] STEP_INSTR = 3'd4;
  localparam logic [2:0] STEP_CKS   = 3'd5;
  // Output steps of a parameter byte
  localparam logic [2:0] STEP_PARAM     = 3'd0;
  localparam logic [2:0] STEP_PARAM_CKS = 3'd1;

  typedef enum logic [1:0] {
    MODE_START   = 2'd0,
    MODE_PARAM   = 2'd1,
    MODE_RX_BYTE = 2'd2,
    MODE_TIMEOUT = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_PENDING      = 3'd0,
    ST_OK           = 3'd1,
    ST_BAD_HEADER   = 3'd2,
    ST_ID_MISMATCH  = 3'd3,
    ST_BAD_LENGTH   = 3'd4,
    ST_BAD_CHECKSUM = 3'd5
  } rx_status_t;

  typedef enum logic [1:0] {
    JOB_START = 2'd0,
    JOB_PARAM = 2'd1,
    JOB_RX    = 2'd2
  } job_kind_t;

  // One classified item, expanded by the back end into result transactions
  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] id;
    logic [7:0] len;
    logic [7:0] data;        // instruction, parameter byte or received byte
    logic       cks_en;      // append checksum byte
    logic [7:0] cks;
    logic       cks_judged;  // checksum byte also closes an empty reply
    logic       rx_done;
    rx_status_t rx_status;
    logic [7:0] rx_length;
    logic       rx_timeout;
    logic [7:0] rx_index;
  } job_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       rx_done;
    rx_status_t rx_status;
    logic [7:0] rx_length;
    logic       rx_timeout;
    logic [7:0] rx_index;
    logic [7:0] rx_data;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/sbpf_front.sv -----
// Front end: accepts items, keeps the framing and reply-check state, classifies
// each item into a job for the back end. Depends on sbpf_pkg.
`default_nettype none

module sbpf_front import sbpf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] mode,
  input  wire logic [7:0] servo_id,
  input  wire logic [7:0] instruction,
  input  wire logic [6:0] param_count,
  input  wire logic [7:0] rx_expect,
  input  wire logic [7:0] data_byte,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data,
  input  wire logic       q_full,
  output logic            push,
  output job_t            job
);

  typedef struct packed {
    rx_status_t status;
    logic [7:0] length;
  } judge_t;

  // Judge a collected reply of n bytes
  function automatic judge_t judge(input logic [7:0] cmd, input logic [7:0] bc,
                                   input logic [7:0] n, input logic hdr,
                                   input logic idk, input logic [7:0] lb,
                                   input logic [7:0] sum);
    judge_t j;
    j.status = ST_OK;
    j.length = n;
    if (cmd == bc || n < MIN_CHECKED) begin
      j.status = ST_OK;
    end else if (!hdr) begin
      j = '{ST_BAD_HEADER, 8'd0};
    end else if (!idk) begin
      j = '{ST_ID_MISMATCH, 8'd0};
    end else if (lb != n - REPLY_HDR_BYTES) begin
      j = '{ST_BAD_LENGTH, 8'd0};
    end else if (sum != SUM_GOOD) begin
      j = '{ST_BAD_CHECKSUM, 8'd0};
    end
    return j;
  endfunction

  logic [7:0] broadcast_id;
  logic [7:0] command_id, command_id_next;
  logic [6:0] params_total, params_total_next;
  logic [6:0] params_sent, params_sent_next;
  logic [7:0] tx_sum, tx_sum_next;
  logic [7:0] reply_expect, reply_expect_next;
  logic [7:0] reply_count, reply_count_next;
  logic [7:0] reply_sum, reply_sum_next;
  logic       header_ok, header_ok_next;
  logic       id_ok, id_ok_next;
  logic [7:0] length_byte, length_byte_next;
  logic       reply_active, reply_active_next;

  logic       accept;
  logic [6:0] pc_sat;
  logic [7:0] start_len;
  logic [7:0] start_sum;
  logic [7:0] param_sum;
  logic [6:0] sent_inc;
  logic [7:0] count_inc;
  logic       hdr_upd, idok_upd;
  logic [7:0] lenb_upd, rsum_upd;
  judge_t     rx_judge, to_judge;

  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign cfg_ready = 1'b1;

  // Saturate the parameter count and precompute the header sum
  assign pc_sat    = ({1'b0, param_count} > 8'(MAX_PARAMS)) ? 7'(MAX_PARAMS) : param_count;
  assign start_len = {1'b0, pc_sat} + LEN_OVERHEAD;
  assign start_sum = servo_id + start_len + instruction;
  assign param_sum = tx_sum + data_byte;
  assign sent_inc  = params_sent + 7'd1;

  // Reply checks with the incoming byte folded in
  assign count_inc = reply_count + 8'd1;
  assign hdr_upd   = header_ok && !(reply_count < POS_ID && data_byte != SYNC_BYTE);
  assign idok_upd  = id_ok && !(reply_count == POS_ID && data_byte != command_id);
  assign lenb_upd  = (reply_count == POS_LENGTH) ? data_byte : length_byte;
  assign rsum_upd  = (reply_count >= POS_ID) ? reply_sum + data_byte : reply_sum;
  assign rx_judge  = judge(command_id, broadcast_id, count_inc, hdr_upd, idok_upd,
                           lenb_upd, rsum_upd);
  assign to_judge  = judge(command_id, broadcast_id, reply_count, header_ok, id_ok,
                           length_byte, reply_sum);

  // Classify the item and compute the next state
  always_comb begin
    command_id_next   = command_id;
    params_total_next = params_total;
    params_sent_next  = params_sent;
    tx_sum_next       = tx_sum;
    reply_expect_next = reply_expect;
    reply_count_next  = reply_count;
    reply_sum_next    = reply_sum;
    header_ok_next    = header_ok;
    id_ok_next        = id_ok;
    length_byte_next  = length_byte;
    reply_active_next = reply_active;
    push              = 1'b0;
    job               = '0;
    if (accept) begin
      case (mode_t'(mode))
        MODE_START: begin
          command_id_next   = servo_id;
          params_total_next = pc_sat;
          params_sent_next  = 7'd0;
          tx_sum_next       = start_sum;
          reply_expect_next = rx_expect;
          reply_count_next  = 8'd0;
          reply_sum_next    = 8'd0;
          header_ok_next    = 1'b1;
          id_ok_next        = 1'b1;
          length_byte_next  = 8'd0;
          reply_active_next = 1'b1;
          push              = 1'b1;
          job.kind          = JOB_START;
          job.id            = servo_id;
          job.len           = start_len;
          job.data          = instruction;
          job.cks           = ~start_sum;
          job.cks_en        = (pc_sat == 7'd0);
          if (pc_sat == 7'd0 && rx_expect == 8'd0) begin
            job.cks_judged    = 1'b1;
            reply_active_next = 1'b0;
          end
        end
        MODE_PARAM: begin
          if (params_sent < params_total) begin
            tx_sum_next      = param_sum;
            params_sent_next = sent_inc;
            push             = 1'b1;
            job.kind         = JOB_PARAM;
            job.data         = data_byte;
            job.cks          = ~param_sum;
            job.cks_en       = (sent_inc == params_total);
            if (sent_inc == params_total && reply_active && reply_expect == 8'd0) begin
              job.cks_judged    = 1'b1;
              reply_active_next = 1'b0;
            end
          end
        end
        MODE_RX_BYTE: begin
          if (reply_active && reply_count < reply_expect) begin
            header_ok_next   = hdr_upd;
            id_ok_next       = idok_upd;
            length_byte_next = lenb_upd;
            reply_sum_next   = rsum_upd;
            reply_count_next = count_inc;
            push             = 1'b1;
            job.kind         = JOB_RX;
            job.data         = data_byte;
            job.rx_index     = reply_count;
            if (count_inc == reply_expect) begin
              reply_active_next = 1'b0;
              job.rx_done       = 1'b1;
              job.rx_status     = rx_judge.status;
              job.rx_length     = rx_judge.length;
            end
          end
        end
        MODE_TIMEOUT: begin
          if (reply_active) begin
            reply_active_next = 1'b0;
            push              = 1'b1;
            job.kind          = JOB_RX;
            job.rx_done       = 1'b1;
            job.rx_status     = to_judge.status;
            job.rx_length     = to_judge.length;
            job.rx_timeout    = (reply_expect != COLLECT_ALL);
          end
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  // Hold the broadcast ID register
  always_ff @(posedge clk) begin
    if (rst) begin
      broadcast_id <= BROADCAST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      broadcast_id <= cfg_data;
    end
  end

  // Advance the framing and reply state
  always_ff @(posedge clk) begin
    if (rst) begin
      command_id   <= 8'd0;
      params_total <= 7'd0;
      params_sent  <= 7'd0;
      tx_sum       <= 8'd0;
      reply_expect <= 8'd0;
      reply_count  <= 8'd0;
      reply_sum    <= 8'd0;
      header_ok    <= 1'b1;
      id_ok        <= 1'b1;
      length_byte  <= 8'd0;
      reply_active <= 1'b0;
    end else begin
      command_id   <= command_id_next;
      params_total <= params_total_next;
      params_sent  <= params_sent_next;
      tx_sum       <= tx_sum_next;
      reply_expect <= reply_expect_next;
      reply_count  <= reply_count_next;
      reply_sum    <= reply_sum_next;
      header_ok    <= header_ok_next;
      id_ok        <= id_ok_next;
      length_byte  <= length_byte_next;
      reply_active <= reply_active_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sbpf_queue.sv -----
// Short job queue between front and back end; push and pop can happen in the same cycle.
// Depends on sbpf_pkg for the job type.
`default_nettype none

module sbpf_queue import sbpf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t wr_job,
  input  wire logic pop,
  output logic      full,
  output logic      head_valid,
  output job_t      head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("job pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("job popped from an empty queue");

endmodule

`default_nettype wire

// ----- rtl/sbpf_back.sv -----
// Back end: expands each queued job into result transactions, one per cycle while
// the output is not stalled, through an output register. Depends on sbpf_pkg.
`default_nettype none

module sbpf_back import sbpf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic head_valid,
  input  wire job_t head,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output result_t   res
);

  logic [2:0] step;
  result_t    cur;
  result_t    cks_res;
  logic       last;
  logic       advance;

  // Checksum transaction, closing an empty reply where flagged
  always_comb begin
    cks_res           = '0;
    cks_res.tx_valid  = 1'b1;
    cks_res.tx_byte   = head.cks;
    cks_res.tx_last   = 1'b1;
    cks_res.rx_done   = head.cks_judged;
    cks_res.rx_status = head.cks_judged ? ST_OK : ST_PENDING;
  end

  // Build the transaction for the current step
  always_comb begin
    cur  = '0;
    last = 1'b1;
    case (head.kind)
      JOB_START: begin
        last         = head.cks_en ? (step == STEP_CKS) : (step == STEP_INSTR);
        cur.tx_valid = 1'b1;
        if (step inside {STEP_SYNC0, STEP_SYNC1}) begin
          cur.tx_byte = SYNC_BYTE;
        end else if (step == STEP_ID) begin
          cur.tx_byte = head.id;
        end else if (step == STEP_LEN) begin
          cur.tx_byte = head.len;
        end else if (step == STEP_INSTR) begin
          cur.tx_byte = head.data;
        end else begin
          cur = cks_res;
        end
      end
      JOB_PARAM: begin
        last = !head.cks_en || (step == STEP_PARAM_CKS);
        if (step == STEP_PARAM) begin
          cur.tx_valid = 1'b1;
          cur.tx_byte  = head.data;
        end else begin
          cur = cks_res;
        end
      end
      JOB_RX: begin
        last           = 1'b1;
        cur.rx_done    = head.rx_done;
        cur.rx_status  = head.rx_status;
        cur.rx_length  = head.rx_length;
        cur.rx_timeout = head.rx_timeout;
        cur.rx_index   = head.rx_index;
        cur.rx_data    = head.data;
      end
      default: begin
        last = 1'b1;
      end
    endcase
  end

  assign advance = head_valid && (!out_valid || !out_stall);
  assign pop     = advance && last;

  // Load the output register, hold it while stalled
  always_ff @(posedge clk) begin
    if (advance) begin
      res <= cur;
    end
  end

  // Advance the step counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        step      <= last ? 3'd0 : step + 3'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst) step <= STEP_CKS)
    else $error("step counter ran past the checksum step");
  a_done_status: assert property (@(posedge clk) disable iff (rst)
                                  (out_valid && res.rx_done) |-> res.rx_status != ST_PENDING)
    else $error("reply closed with pending status");

endmodule

`default_nettype wire

// ----- rtl/servo_bus_packet_framer_checker_core.sv -----
// Servo-bus packet framer and reply checker, top level.
// Path: an accepted item is stored as a job in the queue, and its results leave through the output register.
// Throughput: one item per cycle; a start command yields 5 or 6 transactions and a
// final parameter 2, one per cycle, so the output rate sets the pace; the job queue
// (QUEUE_DEPTH entries) stalls the input when full.
// Reset: synchronous; clears the control state, broadcast ID returns to 254.
`default_nettype none

module servo_bus_packet_framer_checker_core import sbpf_pkg::*; #(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] mode,
  input  wire logic [7:0] servo_id,
  input  wire logic [7:0] instruction,
  input  wire logic [6:0] param_count,
  input  wire logic [7:0] rx_expect,
  input  wire logic [7:0] data_byte,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            tx_valid,
  output logic [7:0]      tx_byte,
  output logic            tx_last,
  output logic            rx_done,
  output logic [2:0]      rx_status,
  output logic [7:0]      rx_length,
  output logic            rx_timeout,
  output logic [7:0]      rx_index,
  output logic [7:0]      rx_data
);

  logic    push;
  logic    pop;
  logic    q_full;
  logic    head_valid;
  job_t    wr_job;
  job_t    head;
  result_t res;

  sbpf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .servo_id    (servo_id),
    .instruction (instruction),
    .param_count (param_count),
    .rx_expect   (rx_expect),
    .data_byte   (data_byte),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .q_full      (q_full),
    .push        (push),
    .job         (wr_job)
  );

  sbpf_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_job     (wr_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  sbpf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .res        (res)
  );

  // Split the result register onto the output fields
  assign tx_valid   = res.tx_valid;
  assign tx_byte    = res.tx_byte;
  assign tx_last    = res.tx_last;
  assign rx_done    = res.rx_done;
  assign rx_status  = res.rx_status;
  assign rx_length  = res.rx_length;
  assign rx_timeout = res.rx_timeout;
  assign rx_index   = res.rx_index;
  assign rx_data    = res.rx_data;

endmodule

`default_nettype wire

// ----- test/tb_servo_bus_packet_framer_checker_core.sv -----
// Self-checking testbench for servo_bus_packet_framer_checker_core.
// Predicts every tx/rx transaction from the stimulus in its own model and
// compares field by field. Depends only on sbpf_pkg and the core RTL.
`default_nettype none

module tb_servo_bus_packet_framer_checker_core import sbpf_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 150;
  localparam int RUN_LIMIT_NS  = 2_000_000;
  localparam int MAX_PRINTED   = 40;
  localparam int RANDOM_ITEMS  = 32;

  // DUT signals, all inputs driven to known values from time zero
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] mode = MODE_START;
  logic [7:0] servo_id = '0;
  logic [7:0] instruction = '0;
  logic [6:0] param_count = '0;
  logic [7:0] rx_expect = '0;
  logic [7:0] data_byte = '0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       tx_last;
  logic       rx_done;
  logic [2:0] rx_status;
  logic [7:0] rx_length;
  logic       rx_timeout;
  logic [7:0] rx_index;
  logic [7:0] rx_data;

  // Framer/checker model state
  logic [7:0] bcast_id = BROADCAST_RESET;
  logic [7:0] cmd_id = '0;
  logic [6:0] n_params = '0;
  logic [6:0] n_sent = '0;
  logic [7:0] frame_sum = '0;
  logic [7:0] reply_want = '0;
  logic [7:0] reply_got = '0;
  logic [7:0] reply_sum = '0;
  logic       hdr_ok = 1'b1;
  logic       id_match = 1'b1;
  logic [7:0] reply_len_byte = '0;
  logic       reply_open = 1'b0;

  result_t pending_results[$];

  // Bookkeeping
  int errors = 0;
  int items_accepted = 0;
  int productive_items = 0;
  int results_checked = 0;
  int timeouts_flagged = 0;
  int input_stall_cycles = 0;
  int verdicts[6] = '{default: 0};
  int burst_left = 0;
  bit steady = 1'b0;
  int hold_request = 0;

  servo_bus_packet_framer_checker_core uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .servo_id   (servo_id),
    .instruction(instruction),
    .param_count(param_count),
    .rx_expect  (rx_expect),
    .data_byte  (data_byte),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .tx_valid   (tx_valid),
    .tx_byte    (tx_byte),
    .tx_last    (tx_last),
    .rx_done    (rx_done),
    .rx_status  (rx_status),
    .rx_length  (rx_length),
    .rx_timeout (rx_timeout),
    .rx_index   (rx_index),
    .rx_data    (rx_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Hard stop in case the core hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("Timeout: %0d transactions still expected", pending_results.size());
    $display("FAIL servo_bus_packet_framer_checker_core");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Model
  // ---------------------------------------------------------------------------

  function automatic result_t make_result(logic tv, logic [7:0] tb, logic tl, logic rd,
                                          rx_status_t rs, logic [7:0] rl, logic rt,
                                          logic [7:0] ri, logic [7:0] rdat);
    result_t r;
    r.tx_valid   = tv;
    r.tx_byte    = tb;
    r.tx_last    = tl;
    r.rx_done    = rd;
    r.rx_status  = rs;
    r.rx_length  = rl;
    r.rx_timeout = rt;
    r.rx_index   = ri;
    r.rx_data    = rdat;
    return r;
  endfunction

  // Judge the collected reply; broadcast and short replies pass unchecked
  function automatic rx_status_t judge_reply(output logic [7:0] len);
    len = reply_got;
    if (cmd_id == bcast_id || reply_got < MIN_CHECKED) return ST_OK;
    len = '0;
    if (!hdr_ok) return ST_BAD_HEADER;
    if (!id_match) return ST_ID_MISMATCH;
    if (reply_len_byte != 8'(reply_got - REPLY_HDR_BYTES)) return ST_BAD_LENGTH;
    if (reply_sum != SUM_GOOD) return ST_BAD_CHECKSUM;
    len = reply_got;
    return ST_OK;
  endfunction

  function automatic void push_verdict(result_t r);
    pending_results.push_back(r);
    verdicts[int'(r.rx_status)]++;
    if (r.rx_timeout) timeouts_flagged++;
  endfunction

  // Checksum byte; it also closes a reply that expects no bytes
  function automatic void push_checksum();
    if (reply_open && reply_want == 8'd0) begin
      reply_open = 1'b0;
      push_verdict(make_result(1'b1, ~frame_sum, 1'b1, 1'b1, ST_OK, '0, 1'b0, '0, '0));
    end else begin
      pending_results.push_back(make_result(1'b1, ~frame_sum, 1'b1, 1'b0, ST_PENDING,
                                            '0, 1'b0, '0, '0));
    end
  endfunction

  function automatic void push_tx(logic [7:0] b);
    pending_results.push_back(make_result(1'b1, b, 1'b0, 1'b0, ST_PENDING, '0, 1'b0, '0, '0));
  endfunction

  // Advance the model by one accepted item and queue its transactions
  function automatic void frame_and_check(mode_t m, logic [7:0] id, logic [7:0] ins,
                                          logic [6:0] pc, logic [7:0] want,
                                          logic [7:0] d);
    int before_cnt;
    logic [7:0] len_byte;
    logic [7:0] pos;
    logic [7:0] len;
    rx_status_t st;
    before_cnt = pending_results.size();
    case (m)
      MODE_START: begin
        if (int'(pc) > MAX_PARAMS) pc = 7'(MAX_PARAMS);
        len_byte = 8'(pc) + LEN_OVERHEAD;
        cmd_id = id;
        n_params = pc;
        n_sent = '0;
        frame_sum = id + len_byte + ins;
        reply_want = want;
        reply_got = '0;
        reply_sum = '0;
        hdr_ok = 1'b1;
        id_match = 1'b1;
        reply_len_byte = '0;
        reply_open = 1'b1;
        push_tx(SYNC_BYTE);
        push_tx(SYNC_BYTE);
        push_tx(id);
        push_tx(len_byte);
        push_tx(ins);
        if (n_params == '0) push_checksum();
      end
      MODE_PARAM: begin
        if (n_sent < n_params) begin
          frame_sum = frame_sum + d;
          n_sent = n_sent + 7'd1;
          push_tx(d);
          if (n_sent == n_params) push_checksum();
        end
      end
      MODE_RX_BYTE: begin
        if (reply_open && reply_got < reply_want) begin
          pos = reply_got;
          if (pos < POS_ID) begin
            if (d != SYNC_BYTE) hdr_ok = 1'b0;
          end else begin
            reply_sum = reply_sum + d;
            if (pos == POS_ID && d != cmd_id) id_match = 1'b0;
            if (pos == POS_LENGTH) reply_len_byte = d;
          end
          reply_got = reply_got + 8'd1;
          if (reply_got == reply_want) begin
            st = judge_reply(len);
            reply_open = 1'b0;
            push_verdict(make_result(1'b0, '0, 1'b0, 1'b1, st, len, 1'b0, pos, d));
          end else begin
            pending_results.push_back(make_result(1'b0, '0, 1'b0, 1'b0, ST_PENDING,
                                                  '0, 1'b0, pos, d));
          end
        end
      end
      default: begin
        if (reply_open) begin
          st = judge_reply(len);
          reply_open = 1'b0;
          push_verdict(make_result(1'b0, '0, 1'b0, 1'b1, st, len,
                                   reply_want != COLLECT_ALL, '0, '0));
        end
      end
    endcase
    if (pending_results.size() != before_cnt) productive_items++;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: stall pattern and checker
  // ---------------------------------------------------------------------------

  // Stall in segments of varying density; hold off completely on request
  initial begin : receiver_stall
    int seg_left;
    int pct;
    int hold_n;
    seg_left = 0;
    pct = 0;
    hold_n = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_n = hold_request;
        hold_request = 0;
        out_stall <= 1'b1;
        repeat (hold_n) @(posedge clk);
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(10, 60);
          case ($urandom_range(0, 4))
            0, 1: pct = 0;
            2: pct = 30;
            3: pct = 60;
            default: pct = 85;
          endcase
        end
        seg_left--;
        out_stall <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= MAX_PRINTED) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic compare_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("transaction %0d: %s got %0h expected %0h",
                                results_checked, name, got, want));
  endtask

  task automatic check_result();
    result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("unexpected transaction tx_byte=%0h rx_index=%0d",
                                tx_byte, rx_index));
      return;
    end
    want = pending_results.pop_front();
    results_checked++;
    compare_field("tx_valid", tx_valid, want.tx_valid);
    compare_field("tx_byte", tx_byte, want.tx_byte);
    compare_field("tx_last", tx_last, want.tx_last);
    compare_field("rx_done", rx_done, want.rx_done);
    compare_field("rx_status", rx_status, want.rx_status);
    compare_field("rx_length", rx_length, want.rx_length);
    compare_field("rx_timeout", rx_timeout, want.rx_timeout);
    compare_field("rx_index", rx_index, want.rx_index);
    compare_field("rx_data", rx_data, want.rx_data);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) check_result();
    if (!rst && in_valid && in_stall) input_stall_cycles++;
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one item, hold it until accepted, then idle between bursts
  task automatic send_item(mode_t m, logic [7:0] id, logic [7:0] ins, logic [6:0] pc,
                           logic [7:0] want, logic [7:0] d);
    mode        <= m;
    servo_id    <= id;
    instruction <= ins;
    param_count <= pc;
    rx_expect   <= want;
    data_byte   <= d;
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_accepted++;
    frame_and_check(m, id, ins, pc, want, d);
    if (!steady) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(0, 6);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  task automatic send_start(logic [7:0] id, logic [7:0] ins, logic [6:0] pc,
                            logic [7:0] want);
    send_item(MODE_START, id, ins, pc, want, 8'($urandom));
  endtask

  // Unused fields carry junk to show they are ignored
  task automatic send_byte(mode_t m, logic [7:0] d);
    send_item(m, 8'($urandom), 8'($urandom), 7'($urandom), 8'($urandom), d);
  endtask

  // Build a well-formed reply of n bytes, optionally corrupt one byte, send the first keep
  task automatic send_reply(logic [7:0] id, int n, int bad_at, int keep);
    logic [7:0] bytes_q[$];
    logic [7:0] sum;
    sum = '0;
    for (int i = 0; i < n; i++) begin
      if (i < 2) bytes_q.push_back(SYNC_BYTE);
      else if (i == 2) bytes_q.push_back(id);
      else if (i == 3) bytes_q.push_back(8'(n - 4));
      else bytes_q.push_back(8'($urandom));
      if (i >= 2 && i < n - 1) sum = sum + bytes_q[i];
    end
    if (n >= 5) bytes_q[n - 1] = SUM_GOOD - sum;
    if (bad_at >= 0 && bad_at < n) bytes_q[bad_at] = bytes_q[bad_at] ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < keep && i < n; i++) send_byte(MODE_RX_BYTE, bytes_q[i]);
  endtask

  // Stop offering and wait until every expected transaction has arrived
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_broadcast(logic [7:0] value);
    drain();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    bcast_id = value;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed();
    // empty packet with an empty reply: six transactions, verdict on checksum
    send_start(8'h01, 8'h03, 7'd0, 8'd0);
    // stray parameter, stray byte, stray timeout: all dropped
    send_byte(MODE_PARAM, 8'hA5);
    send_byte(MODE_RX_BYTE, 8'h5A);
    send_byte(MODE_TIMEOUT, 8'h00);
    // two parameters at the byte extremes and a clean six-byte reply
    send_start(8'h05, 8'h02, 7'd2, 8'd6);
    send_byte(MODE_PARAM, 8'h00);
    send_byte(MODE_PARAM, 8'hFF);
    send_reply(8'h05, 6, -1, 6);
    // byte arriving while nothing is expected, then the closing parameter
    send_start(8'h00, 8'hFF, 7'd1, 8'd0);
    send_byte(MODE_RX_BYTE, 8'hFF);
    send_byte(MODE_PARAM, 8'h7E);
    // broadcast ID skips the checks even with a broken header
    send_start(BROADCAST_RESET, 8'h01, 7'd0, 8'd4);
    send_reply(BROADCAST_RESET, 4, 0, 4);
    // collect-until-timeout: no timeout flag
    send_start(8'h80, 8'h55, 7'd0, COLLECT_ALL);
    send_reply(8'h80, 6, -1, 2);
    send_byte(MODE_TIMEOUT, 8'h00);
    // longest parameter list, abandoned by a restart with a one-byte reply
    send_start(8'hFF, 8'h00, 7'(MAX_PARAMS), 8'hFF);
    send_start(8'h10, 8'hAA, 7'd0, 8'd1);
    send_byte(MODE_RX_BYTE, 8'h33);
  endtask

  // Start, parameters and reply; corrupted, truncated or trailed by a stray byte
  task automatic run_exchange();
    logic [7:0] id;
    int pc;
    int n;
    int bad_at;
    int keep;
    id = ($urandom_range(0, 5) == 0) ? bcast_id : 8'($urandom);
    pc = ($urandom_range(0, 11) == 0) ? $urandom_range(64, 127) : $urandom_range(0, 6);
    case ($urandom_range(0, 9))
      0: n = 0;
      1: n = $urandom_range(1, 3);
      default: n = $urandom_range(4, 10);
    endcase
    send_start(id, 8'($urandom), 7'(pc), 8'(n));
    // long lists are cut short and left for the next start to abandon
    if (pc >= 64) begin
      repeat ($urandom_range(1, 4)) send_byte(MODE_PARAM, 8'($urandom));
      return;
    end
    repeat (pc) send_byte(MODE_PARAM, 8'($urandom));
    if (n == 0) return;
    bad_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, n - 1) : -1;
    keep = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n - 1) : n;
    send_reply(id, n, bad_at, keep);
    if (keep < n) send_byte(MODE_TIMEOUT, 8'($urandom));
    else if ($urandom_range(0, 5) == 0) send_byte(MODE_RX_BYTE, 8'($urandom));
  endtask

  // Stray items, or a start with any expected count followed by random items
  task automatic run_noise();
    case ($urandom_range(0, 3))
      0: send_byte(MODE_PARAM, 8'($urandom));
      1: send_byte(MODE_RX_BYTE, 8'($urandom));
      2: send_byte(MODE_TIMEOUT, 8'($urandom));
      default: begin
        send_start(8'($urandom), 8'($urandom), 7'($urandom_range(0, 2)), 8'($urandom));
        repeat ($urandom_range(0, 6)) send_byte(mode_t'($urandom_range(1, 3)), 8'($urandom));
      end
    endcase
  endtask

  task automatic test_random_traffic(int n_items);
    int target;
    target = productive_items + n_items;
    while (productive_items < target) begin
      if ($urandom_range(0, 99) < 78) run_exchange();
      else run_noise();
    end
  endtask

  // Hold the output off while the sender keeps offering, so the core fills up
  task automatic test_backpressure();
    drain();
    steady = 1'b1;
    hold_request = HOLD_CYCLES;
    repeat (6) begin
      send_start(8'($urandom), 8'($urandom), 7'd3, 8'd0);
      repeat (3) send_byte(MODE_PARAM, 8'($urandom));
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    write_broadcast(8'h00);
    test_random_traffic(RANDOM_ITEMS);
    write_broadcast(8'hFF);
    test_random_traffic(RANDOM_ITEMS);
    test_backpressure();
    write_broadcast(8'($urandom));
    test_random_traffic(RANDOM_ITEMS);
    write_broadcast(BROADCAST_RESET);
    test_random_traffic(RANDOM_ITEMS);
    drain();

    $display("Covered %0d items (%0d with output), %0d transactions checked, %0d input stalls",
             items_accepted, productive_items, results_checked, input_stall_cycles);
    $display("Verdicts ok/header/id/length/checksum: %0d/%0d/%0d/%0d/%0d, %0d timeouts flagged",
             verdicts[ST_OK], verdicts[ST_BAD_HEADER], verdicts[ST_ID_MISMATCH],
             verdicts[ST_BAD_LENGTH], verdicts[ST_BAD_CHECKSUM], timeouts_flagged);
    if (errors == 0) begin
      $display("PASS servo_bus_packet_framer_checker_core");
    end else begin
      $display("FAIL servo_bus_packet_framer_checker_core");
    end
    $finish;
  end

endmodule

`default_nettype wire
